// ===== sv/pnftp_pkg.sv =====
// Shared constants, codes and the planar conversion for the packed nibble frame tile block.
`default_nettype none

package pnftp_pkg;

  localparam int unsigned BYTES_PER_ROW_DEF = 128;
  localparam int unsigned ROWS_DEF          = 256;

  // One tile is 8 rows of 8 pixels: four packed bytes per row, four planar bytes per row.
  localparam int unsigned TILE_SIDE  = 8;
  localparam int unsigned TILE_BYTES = 32;
  localparam int unsigned ROW_BYTES  = 4;
  localparam int unsigned TILE_CNT_W = $clog2(TILE_BYTES);
  localparam int unsigned BSEL_W     = $clog2(ROW_BYTES);
  localparam int unsigned TROW_W     = $clog2(TILE_SIDE);

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_TILE  = 2'd2
  } action_t;

  typedef logic [ROW_BYTES-1:0][7:0] row_bytes_t;

  // Gathers one bit plane of an 8-pixel row held as four packed bytes.
  // Byte k carries column 2k in its high nibble and column 2k+1 in its low nibble.
  function automatic logic [7:0] planar_byte(input row_bytes_t rb, input logic [1:0] plane);
    logic [7:0] res;
    res = '0;
    for (int k = 0; k < ROW_BYTES; k++) begin
      res[7 - 2*k] = rb[k][4 + plane];
      res[6 - 2*k] = rb[k][plane];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== sv/pnftp_if.sv =====
// Valid/ready channel interfaces for the request and result sides.
`default_nettype none

interface pnftp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] x;
  logic [7:0] y;
  logic [3:0] color;

  modport source (output valid, action, x, y, color, input ready);
  modport sink (input valid, action, x, y, color, output ready);
endinterface

interface pnftp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_data;
  logic       last_of_run;

  modport source (output valid, result_data, last_of_run, input ready);
  modport sink (input valid, result_data, last_of_run, output ready);
endinterface

`default_nettype wire

// ===== sv/packed_nibble_frame_tile_planar_top.sv =====
// Packed 4-bit frame store with pixel access and planar 8x8 tile readout.
// The frame lives in one single-port synchronous RAM of BYTES_PER_ROW * ROWS bytes, two pixels
// per byte (even column in the high nibble). A pixel write reads the byte, then merges the new
// nibble and writes it back; a pixel read registers the RAM byte, then loads the selected nibble
// into the output register once the output side is free. A tile read fetches four bytes per
// tile row, one RAM read per cycle while the gather buffer has room, and converts each row into
// four planar bytes while the next row is being fetched. The gather buffer holds one row and is
// refilled only after it has been handed to the output side, and a row is handed over only once
// the previous row's planar bytes have all been taken or the last is being taken. The pace of a
// tile is set by the RAM port, with one access per cycle, and by the single row buffer. The store
// is not cleared at reset; read only pixels that were written. Coordinates wrap: byte column
// modulo BYTES_PER_ROW, row modulo ROWS.
`default_nettype none

module packed_nibble_frame_tile_planar_top
  import pnftp_pkg::*;
#(
  parameter int unsigned BYTES_PER_ROW = BYTES_PER_ROW_DEF,
  parameter int unsigned ROWS          = ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  pnftp_in_if.sink    in_bus,
  pnftp_out_if.source out_bus
);

  localparam int unsigned DEPTH  = BYTES_PER_ROW * ROWS;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CW     = $clog2(BYTES_PER_ROW);
  localparam int unsigned RW     = $clog2(ROWS);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WRITE = 4'b0010,
    ST_READ  = 4'b0100,
    ST_TILE  = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic [TILE_CNT_W:0]   rd_cnt_r, rd_cnt_nxt;
  logic                  rd_pend_r, rd_pend_nxt;
  logic [BSEL_W:0]       g_cnt_r, g_cnt_nxt;
  logic [BSEL_W:0]       pb_cnt_r, pb_cnt_nxt;
  logic [BSEL_W-1:0]     pb_idx_r, pb_idx_nxt;
  logic [TROW_W-1:0]     xr_r, xr_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic                  pb_last_r;
  row_bytes_t            g_r;
  row_bytes_t            pb_r;
  logic [7:0]            out_data_r;
  logic                  out_last_r;
  logic [ADDR_W-1:0]     addr_r;
  logic                  nib_r;
  logic [3:0]            color_r;
  logic [4:0]            tile_xc_r;
  logic [4:0]            tile_yr_r;

  logic [7:0]            mem [DEPTH];
  logic [7:0]            mem_rdata_r;
  logic                  mem_we;
  logic                  mem_re;
  logic [ADDR_W-1:0]     mem_addr;
  logic [7:0]            mem_wdata;

  logic [CW-1:0]         col_tab [128];
  logic [RW-1:0]         row_tab [256];
  logic [6:0]            src_col;
  logic [7:0]            src_row;
  logic [ADDR_W-1:0]     calc_addr;

  logic                  in_acc;
  logic                  out_free;
  logic                  rd_issue;
  logic                  xfer;
  logic                  pb_pop;
  logic                  pop_last;
  logic                  rd_load;

  // Wrap tables for byte column and row; built at elaboration.
  for (genvar gi = 0; gi < 128; gi++) begin : g_col_tab
    assign col_tab[gi] = CW'(gi % BYTES_PER_ROW);
  end
  for (genvar gi = 0; gi < 256; gi++) begin : g_row_tab
    assign row_tab[gi] = RW'(gi % ROWS);
  end

  assign in_bus.ready = (state_r == ST_IDLE);
  assign in_acc       = in_bus.valid && in_bus.ready;
  assign out_free     = !out_valid_r || out_bus.ready;

  // In a tile the low tile coordinate bits come from the fetch counter.
  always_comb begin
    if (state_r == ST_TILE) begin
      src_col = {tile_xc_r, rd_cnt_r[BSEL_W-1:0]};
      src_row = {tile_yr_r, rd_cnt_r[TILE_CNT_W-1:BSEL_W]};
    end else begin
      src_col = in_bus.x[7:1];
      src_row = in_bus.y;
    end
  end

  assign calc_addr = ADDR_W'(row_tab[src_row]) * ADDR_W'(BYTES_PER_ROW)
                   + ADDR_W'(col_tab[src_col]);

  assign rd_issue = (state_r == ST_TILE) && !rd_cnt_r[TILE_CNT_W]
                 && ((g_cnt_r + (BSEL_W+1)'(rd_pend_r) < (BSEL_W+1)'(ROW_BYTES)) || xfer);
  assign pb_pop   = (state_r == ST_TILE) && (pb_cnt_r != '0) && out_free;
  assign pop_last = pb_pop && pb_last_r && (pb_idx_r == BSEL_W'(ROW_BYTES - 1));
  assign xfer     = (state_r == ST_TILE) && (g_cnt_r == (BSEL_W+1)'(ROW_BYTES))
                 && ((pb_cnt_r == '0) || ((pb_cnt_r == (BSEL_W+1)'(1)) && pb_pop));
  assign rd_load  = (state_r == ST_READ) && out_free;

  assign mem_re    = (in_acc && ((in_bus.action == ACT_WRITE) || (in_bus.action == ACT_READ)))
                  || rd_issue;
  assign mem_we    = (state_r == ST_WRITE);
  assign mem_addr  = ((state_r == ST_WRITE) || (state_r == ST_READ)) ? addr_r : calc_addr;
  assign mem_wdata = nib_r ? {mem_rdata_r[7:4], color_r} : {color_r, mem_rdata_r[3:0]};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_addr];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    rd_cnt_nxt    = rd_cnt_r;
    rd_pend_nxt   = rd_issue;
    g_cnt_nxt     = g_cnt_r;
    pb_cnt_nxt    = pb_cnt_r;
    pb_idx_nxt    = pb_idx_r;
    xr_nxt        = xr_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_bus.action)
            ACT_WRITE: state_nxt = ST_WRITE;
            ACT_READ:  state_nxt = ST_READ;
            ACT_TILE: begin
              state_nxt  = ST_TILE;
              rd_cnt_nxt = '0;
              g_cnt_nxt  = '0;
              pb_cnt_nxt = '0;
              pb_idx_nxt = '0;
              xr_nxt     = '0;
            end
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WRITE: state_nxt = ST_IDLE;
      ST_READ: begin
        if (rd_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_TILE: begin
        if (rd_issue) begin
          rd_cnt_nxt = rd_cnt_r + 1'b1;
        end
        g_cnt_nxt = (xfer ? '0 : g_cnt_r) + (BSEL_W+1)'(rd_pend_r);
        if (xfer) begin
          pb_cnt_nxt = (BSEL_W+1)'(ROW_BYTES);
          pb_idx_nxt = '0;
          xr_nxt     = xr_r + 1'b1;
        end else if (pb_pop) begin
          pb_cnt_nxt = pb_cnt_r - 1'b1;
          pb_idx_nxt = pb_idx_r + 1'b1;
        end
        if (pb_pop) begin
          out_valid_nxt = 1'b1;
        end
        if (pop_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_cnt_r    <= '0;
      rd_pend_r   <= 1'b0;
      g_cnt_r     <= '0;
      pb_cnt_r    <= '0;
      pb_idx_r    <= '0;
      xr_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      rd_pend_r   <= rd_pend_nxt;
      g_cnt_r     <= g_cnt_nxt;
      pb_cnt_r    <= pb_cnt_nxt;
      pb_idx_r    <= pb_idx_nxt;
      xr_r        <= xr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      addr_r    <= calc_addr;
      nib_r     <= in_bus.x[0];
      color_r   <= in_bus.color;
      tile_xc_r <= in_bus.x[4:0];
      tile_yr_r <= in_bus.y[4:0];
    end
    if ((state_r == ST_TILE) && rd_pend_r) begin
      g_r[g_cnt_r[BSEL_W-1:0]] <= mem_rdata_r;
    end
    if (xfer) begin
      for (int p = 0; p < ROW_BYTES; p++) begin
        pb_r[p] <= planar_byte(g_r, 2'(p));
      end
      pb_last_r <= (xr_r == TROW_W'(TILE_SIDE - 1));
    end
    if (rd_load) begin
      out_data_r <= {4'b0000, nib_r ? mem_rdata_r[3:0] : mem_rdata_r[7:4]};
      out_last_r <= 1'b1;
    end else if (pb_pop) begin
      out_data_r <= pb_r[pb_idx_r];
      out_last_r <= pop_last;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.result_data = out_data_r;
  assign out_bus.last_of_run = out_last_r;

endmodule

`default_nettype wire

// ===== sv/pnftp_checker.sv =====
// Port-level checker for the packed nibble frame tile block and its bind.
`default_nettype none

module pnftp_checker
  import pnftp_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [1:0] in_action,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_data,
  input wire logic       out_last
);

  logic in_beat;

  assign in_beat = in_valid && in_ready;

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data) && $stable(out_last))
    else $error("result beat changed while stalled");

  // Every real request keeps the block busy in the following cycle.
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && ((in_action == ACT_WRITE) || (in_action == ACT_READ)
                || (in_action == ACT_TILE)) |=> !in_ready)
    else $error("request taken while the previous one is in flight");

  // A pixel read on an empty output delivers a single beat with a clear high nibble.
  a_pixel_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && (in_action == ACT_READ) && !out_valid
      |-> ##2 (out_valid && out_last && (out_data[7:4] == 4'h0)))
    else $error("pixel read result missing or malformed");

  // A pixel write produces no result beat.
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && (in_action == ACT_WRITE) && !out_valid |=> !out_valid ##1 !out_valid)
    else $error("pixel write produced a result beat");

endmodule

bind packed_nibble_frame_tile_planar_top pnftp_checker u_pnftp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .in_action (in_bus.action),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .out_data  (out_bus.result_data),
  .out_last  (out_bus.last_of_run)
);

`default_nettype wire

// ===== dv/packed_nibble_frame_tile_planar_top_tb.sv =====
// Self-checking testbench for the packed nibble frame store with planar tile readout.
`timescale 1ns / 100ps

module packed_nibble_frame_tile_planar_top_tb;
  import pnftp_pkg::*;

  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  localparam int unsigned STORE_BYTES = BYTES_PER_ROW_DEF * ROWS_DEF;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n;

  pnftp_in_if  in_bus();
  pnftp_out_if out_bus();

  packed_nibble_frame_tile_planar_top DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  // Shadow of the frame, plus which pixels hold a defined value.
  logic [7:0]   frame_img [STORE_BYTES];
  bit   [255:0] pix_known [256];
  logic [15:0]  known_pixels [$];
  logic [9:0]   filled_tiles [$];
  beat_t        expected_beats [$];

  int in_idle_pct;
  int out_idle_pct;
  int hold_cycles;
  int fail_count;
  int beats_checked;
  int n_writes;
  int n_reads;
  int n_tiles;
  int n_ignored;

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("packed_nibble_frame_tile_planar_top regression: fail");
    $finish;
  end

  function automatic int unsigned byte_index(logic [7:0] px, logic [7:0] py);
    return (int'(py) % ROWS_DEF) * BYTES_PER_ROW_DEF + (int'(px) >> 1) % BYTES_PER_ROW_DEF;
  endfunction

  function automatic logic [3:0] pixel_value(logic [7:0] px, logic [7:0] py);
    logic [7:0] b;
    b = frame_img[byte_index(px, py)];
    return px[0] ? b[3:0] : b[7:4];
  endfunction

  function automatic bit tile_defined(logic [4:0] tx, logic [4:0] ty);
    for (int r = 0; r < TILE_SIDE; r++)
      for (int c = 0; c < TILE_SIDE; c++)
        if (!pix_known[8'(ty * 8 + r)][8'(tx * 8 + c)]) return 1'b0;
    return 1'b1;
  endfunction

  // Updates the shadow frame for one accepted request and queues the beats it owes.
  task automatic model_request(logic [1:0] act, logic [7:0] px, logic [7:0] py,
                               logic [3:0] pc);
    int unsigned idx;
    logic [7:0]  x0;
    logic [7:0]  y0;
    logic [7:0]  plane_bits;
    logic [3:0]  p;
    beat_t       bt;
    case (act)
      ACT_WRITE: begin
        idx = byte_index(px, py);
        if (px[0]) frame_img[idx][3:0] = pc;
        else frame_img[idx][7:4] = pc;
        if (!pix_known[py][px]) begin
          pix_known[py][px] = 1'b1;
          known_pixels.push_back({py, px});
        end
        n_writes++;
      end
      ACT_READ: begin
        bt.data = {4'h0, pixel_value(px, py)};
        bt.last = 1'b1;
        expected_beats.push_back(bt);
        n_reads++;
      end
      ACT_TILE: begin
        x0 = {px[4:0], 3'b000};
        y0 = {py[4:0], 3'b000};
        for (int r = 0; r < TILE_SIDE; r++) begin
          for (int pl = 0; pl < 4; pl++) begin
            plane_bits = '0;
            for (int c = 0; c < TILE_SIDE; c++) begin
              p = pixel_value(8'(x0 + c), 8'(y0 + r));
              plane_bits[7 - c] = p[pl];
            end
            bt.data = plane_bits;
            bt.last = (r == TILE_SIDE - 1) && (pl == 3);
            expected_beats.push_back(bt);
          end
        end
        n_tiles++;
      end
      default: n_ignored++;
    endcase
  endtask

  // Offers one request; valid stays high on return so back-to-back beats need no gap.
  task automatic send_request(logic [1:0] act, logic [7:0] px, logic [7:0] py,
                              logic [3:0] pc);
    int gap;
    gap = 0;
    while ($urandom_range(99) < in_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid  <= 1'b1;
    in_bus.action <= act;
    in_bus.x      <= px;
    in_bus.y      <= py;
    in_bus.color  <= pc;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    model_request(act, px, py, pc);
    @(negedge clk);
  endtask

  task automatic stop_requests();
    in_bus.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic fill_tile(logic [4:0] tx, logic [4:0] ty, bit ramp);
    logic [3:0] pc;
    for (int r = 0; r < TILE_SIDE; r++) begin
      for (int c = 0; c < TILE_SIDE; c++) begin
        pc = ramp ? 4'(r * 8 + c) : 4'($urandom_range(15));
        send_request(ACT_WRITE, 8'(tx * 8 + c), 8'(ty * 8 + r), pc);
      end
    end
    filled_tiles.push_back({ty, tx});
  endtask

  // Corner and mid-frame pixels, both nibbles of a byte, overwrite, and an unused action code.
  task automatic test_pixel_access();
    send_request(ACT_WRITE, 8'd0, 8'd0, 4'hF);
    send_request(ACT_WRITE, 8'd1, 8'd0, 4'h0);
    send_request(ACT_READ, 8'd0, 8'd0, 4'h0);
    send_request(ACT_READ, 8'd1, 8'd0, 4'hF);
    send_request(ACT_WRITE, 8'd255, 8'd255, 4'hA);
    send_request(ACT_WRITE, 8'd254, 8'd255, 4'h5);
    send_request(ACT_READ, 8'd255, 8'd255, 4'h0);
    send_request(ACT_READ, 8'd254, 8'd255, 4'h0);
    send_request(ACT_WRITE, 8'd0, 8'd0, 4'h6);
    send_request(ACT_READ, 8'd0, 8'd0, 4'h0);
    send_request(ACT_READ, 8'd1, 8'd0, 4'h0);
    send_request(ACT_UNUSED, 8'hAA, 8'h55, 4'hA);
    send_request(ACT_UNUSED, 8'h55, 8'hAA, 4'h5);
    send_request(ACT_READ, 8'd255, 8'd255, 4'h0);
    send_request(ACT_WRITE, 8'd128, 8'd127, 4'h9);
    send_request(ACT_WRITE, 8'd127, 8'd128, 4'h3);
    send_request(ACT_READ, 8'd128, 8'd127, 4'h0);
    send_request(ACT_READ, 8'd127, 8'd128, 4'h0);
    stop_requests();
  endtask

  // Last and first tiles, addressed directly and through wrapped tile indices.
  task automatic test_tile_readout();
    fill_tile(5'd31, 5'd31, 1'b1);
    fill_tile(5'd0, 5'd0, 1'b0);
    send_request(ACT_TILE, 8'd255, 8'd255, 4'h0);
    send_request(ACT_TILE, 8'd31, 8'd31, 4'hF);
    send_request(ACT_TILE, 8'd32, 8'd224, 4'h0);
    send_request(ACT_TILE, 8'd0, 8'd0, 4'h0);
    stop_requests();
  endtask

  task automatic test_random_traffic(int n_items, bit new_tile);
    int         sel;
    logic [15:0] pos;
    logic [9:0]  tl;
    logic [7:0]  px;
    logic [7:0]  py;
    if (new_tile) begin
      tl = 10'($urandom_range(1023));
      fill_tile(tl[4:0], tl[9:5], 1'b0);
    end
    repeat (n_items) begin
      sel = $urandom_range(99);
      if (sel < 35) begin
        if ($urandom_range(1) == 0) begin
          tl = filled_tiles[$urandom_range(filled_tiles.size() - 1)];
          px = {tl[4:0], 3'($urandom_range(7))};
          py = {tl[9:5], 3'($urandom_range(7))};
        end else begin
          px = 8'($urandom_range(255));
          py = 8'($urandom_range(255));
        end
        send_request(ACT_WRITE, px, py, 4'($urandom_range(15)));
      end else if (sel < 65) begin
        pos = known_pixels[$urandom_range(known_pixels.size() - 1)];
        send_request(ACT_READ, pos[7:0], pos[15:8], 4'($urandom_range(15)));
      end else if (sel < 92) begin
        tl = filled_tiles[$urandom_range(filled_tiles.size() - 1)];
        // The upper three bits of each tile index must be dropped by the block.
        px = {3'($urandom_range(7)), tl[4:0]};
        py = {3'($urandom_range(7)), tl[9:5]};
        if (tile_defined(tl[4:0], tl[9:5]))
          send_request(ACT_TILE, px, py, 4'($urandom_range(15)));
      end else begin
        send_request(ACT_UNUSED, 8'($urandom_range(255)), 8'($urandom_range(255)),
                     4'($urandom_range(15)));
      end
    end
    stop_requests();
  endtask

  // The receiver stalls for a long stretch while tile reads keep coming.
  task automatic test_output_backpressure();
    int         saved_idle;
    logic [9:0] tl;
    saved_idle  = in_idle_pct;
    in_idle_pct = 0;
    hold_cycles <= 400;
    @(negedge clk);
    repeat (10) begin
      tl = filled_tiles[$urandom_range(filled_tiles.size() - 1)];
      send_request(ACT_TILE, {3'($urandom_range(7)), tl[4:0]},
                   {3'($urandom_range(7)), tl[9:5]}, 4'h0);
    end
    send_request(ACT_READ, 8'd0, 8'd0, 4'h0);
    send_request(ACT_READ, 8'd255, 8'd255, 4'h0);
    stop_requests();
    in_idle_pct = saved_idle;
  endtask

  // Receiver side: random stalls, plus a counted hold-off on request.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_bus.ready <= 1'b0;
        hold_cycles   <= hold_cycles - 1;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    beat_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_beats.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected beat data=%02h last=%0b", $time,
                 out_bus.result_data, out_bus.last_of_run);
      end else begin
        want = expected_beats.pop_front();
        beats_checked++;
        if (out_bus.result_data !== want.data) begin
          fail_count++;
          $display("%0t: result_data expected %02h actual %02h", $time,
                   want.data, out_bus.result_data);
        end
        if (out_bus.last_of_run !== want.last) begin
          fail_count++;
          $display("%0t: last_of_run expected %0b actual %0b", $time,
                   want.last, out_bus.last_of_run);
        end
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_bus.valid  = 1'b0;
    in_bus.action = ACT_WRITE;
    in_bus.x      = '0;
    in_bus.y      = '0;
    in_bus.color  = '0;
    in_idle_pct   = 10;
    out_idle_pct  = 49;
    hold_cycles   = 0;
    fail_count    = 0;
    beats_checked = 0;
    n_writes      = 0;
    n_reads       = 0;
    n_tiles       = 0;
    n_ignored     = 0;
    for (int i = 0; i < 256; i++) pix_known[i] = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_pixel_access();
    test_tile_readout();
    test_random_traffic(69, 1'b1);
    wait_drain();

    in_idle_pct  = 49;
    out_idle_pct = 10;
    test_random_traffic(69, 1'b0);
    wait_drain();
    test_output_backpressure();
    wait_drain();

    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_random_traffic(69, 1'b0);
    wait_drain();

    $display("Covered %0d pixel writes, %0d pixel reads, %0d tile reads, %0d ignored codes.",
             n_writes, n_reads, n_tiles, n_ignored);
    $display("Checked %0d result beats under sender, receiver and long output stalls.",
             beats_checked);
    if (expected_beats.size() != 0)
      $display("%0t: %0d expected beats never arrived", $time, expected_beats.size());
    if (fail_count == 0 && expected_beats.size() == 0) begin
      $display("packed_nibble_frame_tile_planar_top regression: pass");
    end else begin
      $display("packed_nibble_frame_tile_planar_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/pnftp_pkg.sv
sv/pnftp_if.sv
sv/packed_nibble_frame_tile_planar_top.sv
sv/pnftp_checker.sv
dv/packed_nibble_frame_tile_planar_top_tb.sv
